// ----- rtl/core/cpspid_pkg.sv -----
// shared types and constants of the cascaded position and speed controller
package cpspid_pkg;

   localparam int DELTA_W = 16;
   localparam int WORD_W = 32;
   localparam int TURNS_W = 15;
   localparam int VEL_W = 10;
   localparam int GAIN_W = 18;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 18;

   // shared multiplier: signed operand a, unsigned gain-wide operand b
   localparam int MUL_A_W = 34;
   localparam int PROD_W = MUL_A_W + GAIN_W + 1;
   localparam int ACC_W = PROD_W + 1;

   // speed scale and its reciprocal for the divide by a constant
   localparam int SPEED_SCALE = 76;
   localparam int LIMIT_W = 17;
   localparam int Q_W = 10;
   localparam int RECIP_SHIFT = 24;
   localparam int RECIP = (1 << RECIP_SHIFT) / SPEED_SCALE;
   localparam int B_W = 17;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TARGET_TURNS    = 3'd0,
      CSR_TARGET_VELOCITY = 3'd1,
      CSR_LOOP_MODE       = 3'd2,
      CSR_POS_KP          = 3'd3,
      CSR_POS_KI          = 3'd4,
      CSR_POS_KD          = 3'd5,
      CSR_VEL_KP          = 3'd6,
      CSR_VEL_KI          = 3'd7
   } csr_index_type;

   localparam logic MODE_POSITION = 1'b0;
   localparam logic MODE_CASCADE = 1'b1;

   typedef struct packed {
      logic signed [TURNS_W-1:0] target_turns;
      logic [VEL_W-1:0]          target_velocity;
      logic                      loop_mode;
      logic [GAIN_W-1:0]         pos_kp;
      logic [GAIN_W-1:0]         pos_ki;
      logic [GAIN_W-1:0]         pos_kd;
      logic [GAIN_W-1:0]         vel_kp;
      logic [GAIN_W-1:0]         vel_ki;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      target_turns:    15'sd0,
      target_velocity: 10'd20,
      loop_mode:       MODE_POSITION,
      pos_kp:          18'd2048,
      pos_ki:          18'd59,
      pos_kd:          18'd768,
      vel_kp:          18'd92160,
      vel_ki:          18'd384
   };

   typedef enum logic [4:0] {
      OP_NONE,
      OP_TARGET,
      OP_ERROR,
      OP_SUM,
      OP_MUL_KP,
      OP_MUL_KI,
      OP_MUL_KD,
      OP_ADD,
      OP_PID,
      OP_CLAMP,
      OP_QMUL,
      OP_QEST,
      OP_QFIX,
      OP_BCALC,
      OP_MUL_VKP,
      OP_MUL_VKI,
      OP_PI,
      OP_NEG
   } dp_op_type;

   typedef struct packed {
      logic      take;
      dp_op_type op;
      logic      load_out;
   } cmd_type;

endpackage

// ----- rtl/core/cpspid_csr.sv -----
// configuration register file of the controller
module cpspid_csr import cpspid_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_TARGET_TURNS:    cfg_in.target_turns = $signed(csr_wdata[TURNS_W-1:0]);
            CSR_TARGET_VELOCITY: cfg_in.target_velocity = csr_wdata[VEL_W-1:0];
            CSR_LOOP_MODE:       cfg_in.loop_mode = csr_wdata[0];
            CSR_POS_KP:          cfg_in.pos_kp = csr_wdata[GAIN_W-1:0];
            CSR_POS_KI:          cfg_in.pos_ki = csr_wdata[GAIN_W-1:0];
            CSR_POS_KD:          cfg_in.pos_kd = csr_wdata[GAIN_W-1:0];
            CSR_VEL_KP:          cfg_in.vel_kp = csr_wdata[GAIN_W-1:0];
            CSR_VEL_KI:          cfg_in.vel_ki = csr_wdata[GAIN_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/core/cpspid_ctrl.sv -----
// sequencer that steps the datapath through one control tick
module cpspid_ctrl import cpspid_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   input  logic    loop_mode,
   output cmd_type cmd
);

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_TARGET,
      ST_ERROR,
      ST_SUM,
      ST_KP,
      ST_KI,
      ST_KD,
      ST_PADD,
      ST_PID,
      ST_CLAMP,
      ST_QMUL,
      ST_QEST,
      ST_QFIX,
      ST_BCALC,
      ST_VKP,
      ST_VKI,
      ST_VADD,
      ST_PI,
      ST_NEG,
      ST_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      cmd.take = 1'b0;
      cmd.op = OP_NONE;
      cmd.load_out = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = ST_TARGET;
            end
         end
         ST_TARGET: begin
            cmd.op = OP_TARGET;
            state_in = ST_ERROR;
         end
         ST_ERROR: begin
            cmd.op = OP_ERROR;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.op = OP_SUM;
            state_in = ST_KP;
         end
         ST_KP: begin
            cmd.op = OP_MUL_KP;
            state_in = ST_KI;
         end
         ST_KI: begin
            cmd.op = OP_MUL_KI;
            state_in = ST_KD;
         end
         ST_KD: begin
            cmd.op = OP_MUL_KD;
            state_in = ST_PADD;
         end
         ST_PADD: begin
            cmd.op = OP_ADD;
            state_in = ST_PID;
         end
         ST_PID: begin
            cmd.op = OP_PID;
            state_in = (loop_mode == MODE_CASCADE) ? ST_CLAMP : ST_DONE;
         end
         ST_CLAMP: begin
            cmd.op = OP_CLAMP;
            state_in = ST_QMUL;
         end
         ST_QMUL: begin
            cmd.op = OP_QMUL;
            state_in = ST_QEST;
         end
         ST_QEST: begin
            cmd.op = OP_QEST;
            state_in = ST_QFIX;
         end
         ST_QFIX: begin
            cmd.op = OP_QFIX;
            state_in = ST_BCALC;
         end
         ST_BCALC: begin
            cmd.op = OP_BCALC;
            state_in = ST_VKP;
         end
         ST_VKP: begin
            cmd.op = OP_MUL_VKP;
            state_in = ST_VKI;
         end
         ST_VKI: begin
            cmd.op = OP_MUL_VKI;
            state_in = ST_VADD;
         end
         ST_VADD: begin
            cmd.op = OP_ADD;
            state_in = ST_PI;
         end
         ST_PI: begin
            cmd.op = OP_PI;
            state_in = ST_NEG;
         end
         ST_NEG: begin
            cmd.op = OP_NEG;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- rtl/core/cpspid_dp.sv -----
// datapath: loop state, shared multiplier, accumulator and result register
module cpspid_dp import cpspid_pkg::*; #(
   parameter int unsigned COUNTS_PER_TURN = 1560,
   parameter int unsigned INTEGRAL_LIMIT = 750
) (
   input  logic                      clock,
   input  logic                      reset,
   input  cmd_type                   cmd,
   input  cfg_type                   cfg,
   input  logic signed [DELTA_W-1:0] req_encoder_delta,
   output logic signed [WORD_W-1:0]  rsp_drive,
   output logic signed [WORD_W-1:0]  rsp_position_now
);

   localparam int ES_W = $clog2(INTEGRAL_LIMIT + 1) + 1;
   localparam int SHR_W = ACC_W - 8;
   localparam logic [GAIN_W-1:0] CPT_OPND = GAIN_W'(COUNTS_PER_TURN);
   localparam logic signed [WORD_W:0] LIM_POS = (WORD_W + 1)'(INTEGRAL_LIMIT);
   localparam logic signed [WORD_W:0] LIM_NEG = -LIM_POS;
   localparam logic signed [WORD_W-1:0] W_MAX = {1'b0, {(WORD_W - 1){1'b1}}};
   localparam logic signed [WORD_W-1:0] W_MIN = {1'b1, {(WORD_W - 1){1'b0}}};
   localparam logic [LIMIT_W-1:0] SCALE_L = LIMIT_W'(SPEED_SCALE);

   // loop state, cleared by reset
   logic signed [WORD_W-1:0] position_ff, position_in;
   logic signed [ES_W-1:0]   es_ff, es_in;
   logic signed [WORD_W-1:0] prior_pe_ff, prior_pe_in;
   logic signed [WORD_W-1:0] pi_ff, pi_in;
   logic signed [B_W-1:0]    prior_spd_ff, prior_spd_in;

   // working registers
   logic signed [DELTA_W-1:0] delta_ff, delta_in;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [WORD_W-1:0]  err_ff, err_in;
   logic signed [WORD_W:0]    diff_ff, diff_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [WORD_W-1:0]  drive_ff, drive_in;
   logic [LIMIT_W-1:0]        mag_ff, mag_in;
   logic                      neg_ff, neg_in;
   logic [Q_W-1:0]            q_ff, q_in;
   logic signed [B_W-1:0]     b_ff, b_in;
   logic signed [B_W:0]       bdiff_ff, bdiff_in;
   logic signed [WORD_W-1:0]  out_drive_ff, out_pos_ff;

   // shared multiplier
   logic signed [MUL_A_W-1:0] mul_a;
   logic [GAIN_W-1:0]         mul_b;
   logic signed [PROD_W-1:0]  mul_p;

   // helpers
   logic signed [WORD_W:0]    err_wide;
   logic signed [WORD_W:0]    es_sum;
   logic signed [ACC_W-1:0]   acc_adj;
   logic signed [SHR_W-1:0]   acc_shr;
   logic signed [WORD_W-1:0]  acc_sat;
   logic [LIMIT_W-1:0]        limit;
   logic signed [WORD_W:0]    lim_s;
   logic signed [WORD_W:0]    pid_w;
   logic signed [WORD_W:0]    pid_abs;
   logic [LIMIT_W-1:0]        qx76;
   logic [LIMIT_W-1:0]        rem;
   logic signed [B_W-1:0]     qs;
   logic signed [B_W-1:0]     b_calc;

   always_comb begin
      case (cmd.op)
         OP_TARGET: begin
            mul_a = MUL_A_W'(cfg.target_turns);
            mul_b = CPT_OPND;
         end
         OP_MUL_KP: begin
            mul_a = MUL_A_W'(err_ff);
            mul_b = cfg.pos_kp;
         end
         OP_MUL_KI: begin
            mul_a = MUL_A_W'(es_ff);
            mul_b = cfg.pos_ki;
         end
         OP_MUL_KD: begin
            mul_a = MUL_A_W'(diff_ff);
            mul_b = cfg.pos_kd;
         end
         OP_QMUL: begin
            mul_a = $signed({{(MUL_A_W - LIMIT_W){1'b0}}, mag_ff});
            mul_b = GAIN_W'(RECIP);
         end
         OP_MUL_VKP: begin
            mul_a = MUL_A_W'(bdiff_ff);
            mul_b = cfg.vel_kp;
         end
         OP_MUL_VKI: begin
            mul_a = MUL_A_W'(b_ff);
            mul_b = cfg.vel_ki;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * $signed({1'b0, mul_b});

   // position error, saturated to the word range
   assign err_wide = (WORD_W + 1)'($signed(prod_ff[WORD_W-1:0])) - (WORD_W + 1)'(position_ff);
   assign es_sum = (WORD_W + 1)'(es_ff) + (WORD_W + 1)'(err_ff);

   // divide by 256 toward zero, then saturate
   assign acc_adj = acc_ff + (acc_ff[ACC_W-1] ? ACC_W'(255) : ACC_W'(0));
   assign acc_shr = $signed(acc_adj[ACC_W-1:8]);

   always_comb begin
      if ((&acc_shr[SHR_W-1:WORD_W-1]) || !(|acc_shr[SHR_W-1:WORD_W-1])) begin
         acc_sat = acc_shr[WORD_W-1:0];
      end else begin
         acc_sat = acc_shr[SHR_W-1] ? W_MIN : W_MAX;
      end
   end

   // speed limit and clamp of the position output
   assign limit = LIMIT_W'(cfg.target_velocity) * SCALE_L;
   assign lim_s = $signed({{(WORD_W + 1 - LIMIT_W){1'b0}}, limit});
   assign pid_w = (WORD_W + 1)'(drive_ff);
   assign pid_abs = pid_w[WORD_W] ? -pid_w : pid_w;

   // quotient correction
   assign qx76 = LIMIT_W'(q_ff) * SCALE_L;
   assign rem = mag_ff - qx76;

   // speed error against the speed target
   assign qs = $signed({{(B_W - Q_W){1'b0}}, q_ff});
   assign b_calc = neg_ff ? (B_W'(delta_ff) + qs) : (B_W'(delta_ff) - qs);

   always_comb begin
      position_in = position_ff;
      es_in = es_ff;
      prior_pe_in = prior_pe_ff;
      pi_in = pi_ff;
      prior_spd_in = prior_spd_ff;
      delta_in = delta_ff;
      err_in = err_ff;
      diff_in = diff_ff;
      acc_in = acc_ff;
      drive_in = drive_ff;
      mag_in = mag_ff;
      neg_in = neg_ff;
      q_in = q_ff;
      b_in = b_ff;
      bdiff_in = bdiff_ff;

      if (cmd.take) begin
         delta_in = req_encoder_delta;
         position_in = position_ff + WORD_W'(req_encoder_delta);
      end

      case (cmd.op)
         OP_ERROR: begin
            if (err_wide[WORD_W] != err_wide[WORD_W-1]) begin
               err_in = err_wide[WORD_W] ? W_MIN : W_MAX;
            end else begin
               err_in = err_wide[WORD_W-1:0];
            end
         end
         OP_SUM: begin
            if (es_sum > LIM_POS) begin
               es_in = ES_W'(LIM_POS);
            end else if (es_sum < LIM_NEG) begin
               es_in = ES_W'(LIM_NEG);
            end else begin
               es_in = ES_W'(es_sum);
            end
            diff_in = (WORD_W + 1)'(err_ff) - (WORD_W + 1)'(prior_pe_ff);
            prior_pe_in = err_ff;
         end
         OP_MUL_KP: begin
            acc_in = '0;
         end
         OP_MUL_KI, OP_MUL_KD, OP_MUL_VKI, OP_ADD: begin
            acc_in = acc_ff + ACC_W'(prod_ff);
         end
         OP_PID: begin
            drive_in = acc_sat;
         end
         OP_CLAMP: begin
            if (pid_w > lim_s) begin
               mag_in = limit;
               neg_in = 1'b0;
            end else if (pid_w < -lim_s) begin
               mag_in = limit;
               neg_in = 1'b1;
            end else begin
               mag_in = pid_abs[LIMIT_W-1:0];
               neg_in = pid_w[WORD_W];
            end
         end
         OP_QEST: begin
            q_in = prod_ff[RECIP_SHIFT +: Q_W];
         end
         OP_QFIX: begin
            if (rem >= SCALE_L) begin
               q_in = q_ff + Q_W'(1);
            end
         end
         OP_BCALC: begin
            b_in = b_calc;
            bdiff_in = (B_W + 1)'(b_calc) - (B_W + 1)'(prior_spd_ff);
            acc_in = ACC_W'($signed({pi_ff, 8'b0}));
         end
         OP_PI: begin
            pi_in = acc_sat;
            prior_spd_in = b_ff;
         end
         OP_NEG: begin
            drive_in = (pi_ff == W_MIN) ? W_MAX : -pi_ff;
         end
         default: begin
            acc_in = acc_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
         es_ff <= '0;
         prior_pe_ff <= '0;
         pi_ff <= '0;
         prior_spd_ff <= '0;
      end else begin
         position_ff <= position_in;
         es_ff <= es_in;
         prior_pe_ff <= prior_pe_in;
         pi_ff <= pi_in;
         prior_spd_ff <= prior_spd_in;
      end
   end

   always_ff @(posedge clock) begin
      delta_ff <= delta_in;
      prod_ff <= mul_p;
      err_ff <= err_in;
      diff_ff <= diff_in;
      acc_ff <= acc_in;
      drive_ff <= drive_in;
      mag_ff <= mag_in;
      neg_ff <= neg_in;
      q_ff <= q_in;
      b_ff <= b_in;
      bdiff_ff <= bdiff_in;
      if (cmd.load_out) begin
         out_drive_ff <= drive_ff;
         out_pos_ff <= position_ff;
      end
   end

   assign rsp_drive = out_drive_ff;
   assign rsp_position_now = out_pos_ff;

endmodule

// ----- rtl/core/cascaded_position_speed_pid_unit.sv -----
// top level of the cascaded position and speed controller
//
//   channel   direction  handshake              payload
//   req       in         req_valid / req_stall  req_encoder_delta
//   rsp       out        rsp_valid / rsp_stall  rsp_drive, rsp_position_now
//   csr       in         csr_write_enable       csr_index, csr_wdata
//
// cascade mode adds the speed pi steps to a tick; the sequencer steps one shared
// multiplier through the target, gain and reciprocal products; reset is synchronous
// and returns the loop state, csr registers and sequencer to their defaults
// the result sits in an output register, so the next tick is taken while the
// previous result waits on rsp_stall; the sequencer only holds in its last step
// if a result is still waiting there
module cascaded_position_speed_pid_unit import cpspid_pkg::*; #(
   parameter int unsigned COUNTS_PER_TURN = 1560,
   parameter int unsigned INTEGRAL_LIMIT = 750
) (
   input  logic                      clock,
   input  logic                      reset,
   // tick input
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [DELTA_W-1:0] req_encoder_delta,
   // drive result
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [WORD_W-1:0]  rsp_drive,
   output logic signed [WORD_W-1:0]  rsp_position_now,
   // register writes
   input  logic                      csr_write_enable,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wdata
);

   cfg_type cfg;
   cmd_type cmd;

   // gains, targets and mode
   cpspid_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .cfg              (cfg)
   );

   // sequencer: position pid steps, then the speed pi steps in cascade mode
   cpspid_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .loop_mode (cfg.loop_mode),
      .cmd       (cmd)
   );

   // arithmetic and loop state
   cpspid_dp #(
      .COUNTS_PER_TURN (COUNTS_PER_TURN),
      .INTEGRAL_LIMIT  (INTEGRAL_LIMIT)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .cfg               (cfg),
      .req_encoder_delta (req_encoder_delta),
      .rsp_drive         (rsp_drive),
      .rsp_position_now  (rsp_position_now)
   );

endmodule
